@@ rtl/psg_three_tone_noise_envelope_defines.svh @@
// Assertion macros shared by the sound generator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef PSG_THREE_TONE_NOISE_ENVELOPE_DEFINES_SVH
`define PSG_THREE_TONE_NOISE_ENVELOPE_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define PSG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define PSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/psg_pkg.sv @@
// Shared types, register numbers and the volume table of the sound generator.
// Depends on nothing; every other file but the assertion macro header imports it.
package psg_pkg;

    localparam int unsigned NUM_CHAN = 3;
    localparam int unsigned NUM_REGS = 16;
    localparam int unsigned SAMPLE_W = 14;
    localparam int unsigned APB_AW   = 3;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    localparam logic [3:0] REG_NOISE_PER = 4'd6;
    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_LEVEL_A   = 4'd8;
    localparam logic [3:0] REG_ENV_LO    = 4'd11;
    localparam logic [3:0] REG_ENV_HI    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

    localparam logic CFG_CHANNEL_MASK = 1'b0;

    typedef logic [NUM_REGS-1:0][7:0] t_reg_array;

    typedef struct packed {
        logic holding;
        logic hold;
        logic alternate;
        logic attack;
    } t_env_flags;

    typedef struct packed {
        logic       tick;
        logic       shape_wr;
        logic [3:0] shape;
    } t_tick_ctl;

    function automatic logic [SAMPLE_W-1:0] level_lookup(input logic [4:0] idx);
        logic [SAMPLE_W-1:0] val;
        case (idx)
            5'd0:  val = 14'd0;
            5'd1:  val = 14'd0;
            5'd2:  val = 14'd72;
            5'd3:  val = 14'd85;
            5'd4:  val = 14'd101;
            5'd5:  val = 14'd121;
            5'd6:  val = 14'd144;
            5'd7:  val = 14'd171;
            5'd8:  val = 14'd203;
            5'd9:  val = 14'd241;
            5'd10: val = 14'd287;
            5'd11: val = 14'd341;
            5'd12: val = 14'd406;
            5'd13: val = 14'd483;
            5'd14: val = 14'd574;
            5'd15: val = 14'd683;
            5'd16: val = 14'd812;
            5'd17: val = 14'd965;
            5'd18: val = 14'd1148;
            5'd19: val = 14'd1365;
            5'd20: val = 14'd1624;
            5'd21: val = 14'd1931;
            5'd22: val = 14'd2296;
            5'd23: val = 14'd2731;
            5'd24: val = 14'd3247;
            5'd25: val = 14'd3862;
            5'd26: val = 14'd4592;
            5'd27: val = 14'd5461;
            5'd28: val = 14'd6494;
            5'd29: val = 14'd7723;
            5'd30: val = 14'd9185;
            default: val = 14'd10922;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/psg_if.sv @@
// Valid/ready channel interfaces for command beats and result beats.
// Depends on psg_pkg.
interface psg_cmd_if;
    import psg_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [3:0] reg_addr;
    logic [7:0] write_data;

    modport source (output valid, command, reg_addr, write_data, input ready);
    modport sink   (input valid, command, reg_addr, write_data, output ready);
endinterface

interface psg_res_if;
    import psg_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic [7:0]          read_data;

    modport source (output valid, sample, read_data, input ready);
    modport sink   (input valid, sample, read_data, output ready);
endinterface

@@ rtl/psg_regs.sv @@
// Sixteen byte-wide control registers with one write port and one read port.
// Depends on psg_pkg.
module psg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [3:0]         i_wr_addr,
    input  logic [7:0]         i_wr_data,
    input  logic [3:0]         i_rd_addr,
    output logic [7:0]         o_rd_data,
    output psg_pkg::t_reg_array o_regs
);
    import psg_pkg::*;

    t_reg_array r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (i_wr_en) begin
            r_regs[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_regs[i_rd_addr];
    assign o_regs    = r_regs;
endmodule

@@ rtl/psg_tick.sv @@
// Tone dividers, noise shift register, envelope and mixer for one tick.
// Depends on psg_pkg; the sample output is the mix of the state after the tick.
module psg_tick (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psg_pkg::t_tick_ctl            i_ctl,
    input  psg_pkg::t_reg_array           i_regs,
    input  logic [psg_pkg::NUM_CHAN-1:0]  i_mask,
    output logic [psg_pkg::SAMPLE_W-1:0]  o_sample
);
    import psg_pkg::*;

    logic [NUM_CHAN-1:0][11:0] r_tone_cnt, n_tone_cnt;
    logic [NUM_CHAN-1:0]       r_tone_ph,  n_tone_ph;
    logic [5:0]                r_noise_cnt, n_noise_cnt;
    logic [16:0]               r_noise_sr,  n_noise_sr;
    logic [15:0]               r_env_cnt,   n_env_cnt;
    logic [4:0]                r_env_step,  n_env_step;
    t_env_flags                r_env_flags, n_env_flags;

    logic [6:0]  noise_inc;
    logic [16:0] env_inc;
    logic [15:0] env_per;
    logic [5:0]  step_inc;
    logic [4:0]  env_vol;
    logic [14:0] mix_sum;

    // Noise, envelope and tone dividers.
    always_comb begin
        logic [11:0] per;
        logic [12:0] inc;
        per         = '0;
        inc         = '0;
        n_tone_cnt  = r_tone_cnt;
        n_tone_ph   = r_tone_ph;
        n_noise_cnt = r_noise_cnt;
        n_noise_sr  = r_noise_sr;
        n_env_cnt   = r_env_cnt;
        n_env_step  = r_env_step;
        n_env_flags = r_env_flags;
        noise_inc   = {1'b0, r_noise_cnt} + 7'd1;
        env_inc     = {1'b0, r_env_cnt} + 17'd1;
        env_per     = {i_regs[REG_ENV_HI], i_regs[REG_ENV_LO]};
        step_inc    = {1'b0, r_env_step} + 6'd1;

        if (i_ctl.shape_wr) begin
            n_env_flags.attack    = i_ctl.shape[2];
            n_env_flags.alternate = i_ctl.shape[3] ? i_ctl.shape[1] : i_ctl.shape[2];
            n_env_flags.hold      = i_ctl.shape[3] ? i_ctl.shape[0] : 1'b1;
            n_env_flags.holding   = 1'b0;
            n_env_step            = '0;
            n_env_cnt             = '0;
        end else if (i_ctl.tick) begin
            if (noise_inc[6:1] >= {1'b0, i_regs[REG_NOISE_PER][4:0]}) begin
                n_noise_cnt = '0;
                n_noise_sr  = {~(r_noise_sr[0] ^ r_noise_sr[3]), r_noise_sr[16:1]};
            end else begin
                n_noise_cnt = noise_inc[5:0];
            end

            if (!r_env_flags.holding) begin
                if (env_inc < {1'b0, env_per}) begin
                    n_env_cnt = env_inc[15:0];
                end else begin
                    n_env_cnt = '0;
                    if (step_inc[5]) begin
                        n_env_step = '0;
                        if (r_env_flags.alternate) begin
                            n_env_flags.attack = ~r_env_flags.attack;
                        end
                        if (r_env_flags.hold) begin
                            n_env_step          = 5'd31;
                            n_env_flags.holding = 1'b1;
                        end
                    end else begin
                        n_env_step = step_inc[4:0];
                    end
                end
            end

            for (int ch = 0; ch < NUM_CHAN; ch++) begin
                per = {i_regs[4'(2*ch+1)][3:0], i_regs[4'(2*ch)]};
                inc = {1'b0, r_tone_cnt[ch]} + 13'd1;
                if (inc >= {1'b0, per}) begin
                    n_tone_cnt[ch] = '0;
                    n_tone_ph[ch]  = ~r_tone_ph[ch];
                end else begin
                    n_tone_cnt[ch] = inc[11:0];
                end
            end
        end
    end

    // Mixer works on the post-tick state.
    assign env_vol = n_env_flags.attack ? n_env_step : ~n_env_step;

    always_comb begin
        logic [7:0] lv;
        logic       tone_ok;
        logic       noise_ok;
        mix_sum = '0;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            lv       = i_regs[REG_LEVEL_A + 4'(ch)];
            tone_ok  = n_tone_ph[ch] | i_regs[REG_MIXER][ch];
            noise_ok = n_noise_sr[0] | i_regs[REG_MIXER][ch+NUM_CHAN];
            if (!i_mask[ch] && tone_ok && noise_ok) begin
                mix_sum = mix_sum + {1'b0, level_lookup(lv[4] ? env_vol : {lv[3:0], 1'b1})};
            end
        end
    end

    assign o_sample = mix_sum[SAMPLE_W:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_cnt  <= '0;
            r_tone_ph   <= '0;
            r_noise_cnt <= '0;
            r_noise_sr  <= '0;
            r_env_cnt   <= '0;
            r_env_step  <= '0;
            r_env_flags <= '0;
        end else begin
            r_tone_cnt  <= n_tone_cnt;
            r_tone_ph   <= n_tone_ph;
            r_noise_cnt <= n_noise_cnt;
            r_noise_sr  <= n_noise_sr;
            r_env_cnt   <= n_env_cnt;
            r_env_step  <= n_env_step;
            r_env_flags <= n_env_flags;
        end
    end
endmodule

@@ rtl/psg_three_tone_noise_envelope.sv @@
// Top level of the three-tone sound generator: channel handshake, APB mask register.
// Depends on psg_pkg, psg_if, psg_regs, psg_tick and the assertion macro header.
//
// Each command beat is a tick, a register write or a register read, and each
// one yields exactly one result beat: a tick returns the mixed sample (half the
// summed volume-table values of the audible, unmasked channels), a read returns
// the addressed register byte, and everything else returns zeros. A command beat
// is captured in an input register; when it leaves that register, the generator
// state (tone dividers, 17-bit noise shift register, envelope) and the register
// file are updated from it and the result is loaded into the output register,
// which the downstream side drains at its own pace. The block takes one command
// beat per clock cycle for as long as result beats are taken; a beat passes
// through the input register and then the output register, from which its
// result is presented. Ready drops only when both the input register and the
// output register hold beats and the output is stalled. The synchronous reset
// clears the valid flags, the register file, the generator state and the mask;
// the beat payload registers are not reset. The APB register at byte addresses
// 0 to 3 holds the three-bit channel mask; it reads back, and a write with
// paddr[2] set is ignored. Change it only while no beats are in flight.
`include "psg_three_tone_noise_envelope_defines.svh"

module psg_three_tone_noise_envelope (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    psg_cmd_if.sink                    i_cmd,
    psg_res_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [psg_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import psg_pkg::*;

    // Input register holding one command beat.
    logic       r_s1_valid;
    logic [1:0] r_s1_cmd;
    logic [3:0] r_s1_addr;
    logic [7:0] r_s1_data;

    // Output register holding one result beat.
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;
    logic [7:0]          r_out_rdata;

    logic [NUM_CHAN-1:0] r_chan_mask;

    logic out_take;
    logic s1_fire;
    logic in_ready;
    logic in_fire;
    logic is_tick;
    logic is_write;
    logic is_read;

    t_reg_array          regs;
    logic [7:0]          rd_data;
    logic [SAMPLE_W-1:0] tick_sample;
    t_tick_ctl           tick_ctl;
    logic                cfg_wr;

    assign out_take = !r_out_valid || o_res.ready;
    assign s1_fire  = r_s1_valid && out_take;
    assign in_ready = !r_s1_valid || out_take;
    assign in_fire  = i_cmd.valid && in_ready;

    assign i_cmd.ready     = in_ready;
    assign o_res.valid     = r_out_valid;
    assign o_res.sample    = r_out_sample;
    assign o_res.read_data = r_out_rdata;

    // Command decode; the unused code does nothing and returns zeros.
    always_comb begin
        is_tick  = 1'b0;
        is_write = 1'b0;
        is_read  = 1'b0;
        unique case (r_s1_cmd)
            CMD_TICK:  is_tick  = 1'b1;
            CMD_WRITE: is_write = 1'b1;
            CMD_READ:  is_read  = 1'b1;
            default: ;
        endcase
    end

    // A write to the shape register restarts the envelope.
    assign tick_ctl.tick     = s1_fire && is_tick;
    assign tick_ctl.shape_wr = s1_fire && is_write && (r_s1_addr == REG_ENV_SHAPE);
    assign tick_ctl.shape    = r_s1_data[3:0];

    psg_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (s1_fire && is_write),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (r_s1_data),
        .i_rd_addr (r_s1_addr),
        .o_rd_data (rd_data),
        .o_regs    (regs)
    );

    psg_tick u_tick (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (tick_ctl),
        .i_regs   (regs),
        .i_mask   (r_chan_mask),
        .o_sample (tick_sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_cmd  <= i_cmd.command;
            r_s1_addr <= i_cmd.reg_addr;
            r_s1_data <= i_cmd.write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_sample <= is_tick ? tick_sample : '0;
            r_out_rdata  <= is_read ? rd_data : '0;
        end
    end

    // APB configuration: one word, the channel mask.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_CHANNEL_MASK);
    assign prdata = (paddr[2] == CFG_CHANNEL_MASK) ? {29'd0, r_chan_mask} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_mask <= '0;
        end else if (cfg_wr) begin
            r_chan_mask <= pwdata[NUM_CHAN-1:0];
        end
    end

    // A beat held in the input register is never dropped while the output stalls.
    `PSG_ASSERT_NEXT(a_s1_kept, i_clk, i_rst_n, r_s1_valid && !out_take, r_s1_valid, "input beat lost during output stall")
    // Every beat leaving the input register lands in the output register.
    `PSG_ASSERT_NEXT(a_s1_to_out, i_clk, i_rst_n, s1_fire, r_out_valid, "processed beat did not reach the output register")
    // Back-pressure only when both registers are full.
    `PSG_ASSERT_IMPLY(a_ready_low, i_clk, i_rst_n, !i_cmd.ready, r_s1_valid && r_out_valid && !o_res.ready, "ready low with free space")
    // A result never carries both a sample and read data.
    `PSG_ASSERT_IMPLY(a_one_field, i_clk, i_rst_n, r_out_valid && (r_out_rdata != 8'd0), r_out_sample == '0, "result carries both sample and read data")
endmodule
